// ===== hw/rtl/gsa_pkg.sv =====
// ----------------------------------------------------------------------------
// gsa_pkg
// Shared types, codes and sizes for the grant slot allocator.
// ----------------------------------------------------------------------------
package gsa_pkg;

  localparam int SLOT_COUNT = 128;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int CNT_W      = SLOT_W + 1;

  // commands
  localparam logic [2:0] CMD_ALLOC   = 3'd0;
  localparam logic [2:0] CMD_WRITE   = 3'd1;
  localparam logic [2:0] CMD_RELEASE = 3'd2;
  localparam logic [2:0] CMD_MAP     = 3'd3;
  localparam logic [2:0] CMD_UNMAP   = 3'd4;
  localparam logic [2:0] CMD_READ    = 3'd5;

  // result codes
  localparam logic [2:0] RC_OK      = 3'd0;
  localparam logic [2:0] RC_INVALID = 3'd1;
  localparam logic [2:0] RC_NOSPACE = 3'd2;
  localparam logic [2:0] RC_BUSY    = 3'd3;
  localparam logic [2:0] RC_RANGE   = 3'd4;

  // slot states
  localparam logic [1:0] ST_FREE     = 2'd0;
  localparam logic [1:0] ST_RESERVED = 2'd1;
  localparam logic [1:0] ST_MAPPED   = 2'd2;

  // controller phases
  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_DECODE  = 4'd1;
  localparam logic [3:0] PH_POP     = 4'd2;
  localparam logic [3:0] PH_POP_WR  = 4'd3;
  localparam logic [3:0] PH_SCAN    = 4'd4;
  localparam logic [3:0] PH_MARK    = 4'd5;
  localparam logic [3:0] PH_COMPACT = 4'd6;
  localparam logic [3:0] PH_CHECK   = 4'd7;
  localparam logic [3:0] PH_APPLY   = 4'd8;
  localparam logic [3:0] PH_FIN_RD  = 4'd9;
  localparam logic [3:0] PH_FINAL   = 4'd10;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [6:0]  slot;
    logic [7:0]  count;
    logic [15:0] domain_id;
    logic [31:0] grant_ref;
    logic        writable;
    logic        shared;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [6:0]  slot_out;
    logic [1:0]  slot_state;
    logic [15:0] domain_out;
    logic [31:0] ref_out;
    logic        read_only_out;
    logic [7:0]  free_count;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic [3:0] op;
    logic       accept;
    logic       load_out;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic dec_done;
    logic dec_pop;
    logic dec_scan;
    logic dec_check;
    logic scan_hit;
    logic scan_miss;
    logic walk_end;
    logic chk_fail;
    logic chk_apply;
    logic chk_final;
  } sts_t;

endpackage

// ===== hw/rtl/gsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// gsa_ctrl
// Phase sequencer for the allocator and the input/output handshakes.
// ----------------------------------------------------------------------------
module gsa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  gsa_pkg::sts_t sts,
  output gsa_pkg::ctl_t ctl
);

  logic [3:0] state;
  logic [3:0] state_next;
  logic       load;

  assign in_ready = (state == gsa_pkg::PH_IDLE);
  assign load     = (state == gsa_pkg::PH_FINAL) && (!out_valid || out_ready);

  // {op, accept, load_out}
  assign ctl = {state, in_valid && in_ready, load};

  // next phase
  always_comb begin
    state_next = state;
    case (state)
      gsa_pkg::PH_IDLE: begin
        if (in_valid) state_next = gsa_pkg::PH_DECODE;
      end
      gsa_pkg::PH_DECODE: begin
        if (sts.dec_done)       state_next = gsa_pkg::PH_FIN_RD;
        else if (sts.dec_pop)   state_next = gsa_pkg::PH_POP;
        else if (sts.dec_scan)  state_next = gsa_pkg::PH_SCAN;
        else if (sts.dec_check) state_next = gsa_pkg::PH_CHECK;
      end
      gsa_pkg::PH_POP:    state_next = gsa_pkg::PH_POP_WR;
      gsa_pkg::PH_POP_WR: state_next = gsa_pkg::PH_FIN_RD;
      gsa_pkg::PH_SCAN: begin
        if (sts.scan_hit)       state_next = gsa_pkg::PH_MARK;
        else if (sts.scan_miss) state_next = gsa_pkg::PH_FIN_RD;
      end
      gsa_pkg::PH_MARK: begin
        if (sts.walk_end) state_next = gsa_pkg::PH_COMPACT;
      end
      gsa_pkg::PH_COMPACT: begin
        if (sts.walk_end) state_next = gsa_pkg::PH_FIN_RD;
      end
      gsa_pkg::PH_CHECK: begin
        if (sts.chk_fail || sts.chk_final) state_next = gsa_pkg::PH_FIN_RD;
        else if (sts.chk_apply)            state_next = gsa_pkg::PH_APPLY;
      end
      gsa_pkg::PH_APPLY: begin
        if (sts.walk_end) state_next = gsa_pkg::PH_FIN_RD;
      end
      gsa_pkg::PH_FIN_RD: state_next = gsa_pkg::PH_FINAL;
      gsa_pkg::PH_FINAL: begin
        if (load) state_next = gsa_pkg::PH_IDLE;
      end
      default: state_next = gsa_pkg::PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gsa_pkg::PH_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load)           out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

// ===== hw/rtl/gsa_datapath.sv =====
// ----------------------------------------------------------------------------
// gsa_datapath
// Slot tables, free stack, walk counters and result register.
// ----------------------------------------------------------------------------
module gsa_datapath (
  input  logic          clk,
  input  logic          rst,
  input  gsa_pkg::ctl_t ctl,
  output gsa_pkg::sts_t sts,
  input  gsa_pkg::in_t  in_data,
  output gsa_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [6:0]    cfg_wdata
);

  localparam int SW = gsa_pkg::SLOT_W;
  localparam int CW = gsa_pkg::CNT_W;
  localparam logic [CW-1:0] FULL = CW'(gsa_pkg::SLOT_COUNT);
  localparam logic [SW-1:0] TOP  = SW'(gsa_pkg::SLOT_COUNT - 1);

  // memories: {read_only, state}, entry, free stack
  logic [2:0]    st_mem  [gsa_pkg::SLOT_COUNT];
  logic [15:0]   dom_mem [gsa_pkg::SLOT_COUNT];
  logic [31:0]   ref_mem [gsa_pkg::SLOT_COUNT];
  logic [SW-1:0] stk_mem [gsa_pkg::SLOT_COUNT];
  logic [gsa_pkg::SLOT_COUNT-1:0] st_vld;
  logic [gsa_pkg::SLOT_COUNT-1:0] stk_vld;

  logic [6:0]    search_start;
  gsa_pkg::in_t  req;
  logic [CW-1:0] depth;
  logic [2:0]    status_r;
  logic [SW-1:0] sout;
  logic [CW-1:0] icnt, pcnt, jcnt, run_len;
  logic          rd_pend;
  logic [SW-1:0] run_first;

  logic [2:0]    st_q;
  logic          st_vq;
  logic [SW-1:0] stk_q, stk_ridx;
  logic          stk_vq;
  logic [15:0]   dom_q;
  logic [31:0]   ref_q;

  // read ports and write ports
  logic          st_re, stk_re, ent_re;
  logic [SW-1:0] st_ra, stk_ra;
  logic          st_we, stk_we, ent_we;
  logic [SW-1:0] st_wa, stk_wa, ent_wa;
  logic [2:0]    st_wd;
  logic [SW-1:0] stk_wd;

  logic [2:0]    st_val;
  logic [SW-1:0] stk_val;
  logic [CW-1:0] len_chk, walk_len;
  logic          issue, clr;
  logic [CW:0]   span;
  logic [SW-1:0] paddr, first_c;
  logic [CW-1:0] run_eff, run_n;
  logic          is_free, chk_bad, in_run;
  logic [2:0]    dec_rc, chk_rc;
  logic [CW-1:0] hi_end;

  // status flags
  logic dec_done, dec_pop, dec_scan, dec_check;
  logic scan_hit, scan_miss, walk_end;
  logic chk_fail, chk_apply, chk_final, chk_last;

  assign sts = {dec_done, dec_pop, dec_scan, dec_check, scan_hit, scan_miss,
                walk_end, chk_fail, chk_apply, chk_final};

  assign st_val  = st_vq ? st_q : 3'b000;
  assign stk_val = stk_vq ? stk_q : (TOP - stk_ridx);

  assign len_chk = (req.cmd == gsa_pkg::CMD_RELEASE || req.cmd == gsa_pkg::CMD_MAP)
                   ? req.count : CW'(1);
  assign span    = {1'b0, CW'(req.slot)} + {1'b0, req.count};
  assign hi_end  = CW'(sout) + req.count;

  // walk length of the current phase
  always_comb begin
    case (ctl.op)
      gsa_pkg::PH_SCAN:    walk_len = FULL;
      gsa_pkg::PH_COMPACT: walk_len = depth;
      gsa_pkg::PH_CHECK:   walk_len = len_chk;
      default:             walk_len = '0;
    endcase
  end
  assign issue = icnt < walk_len;

  // decode
  always_comb begin
    dec_done  = 1'b0;
    dec_pop   = 1'b0;
    dec_scan  = 1'b0;
    dec_check = 1'b0;
    dec_rc    = gsa_pkg::RC_OK;
    case (req.cmd)
      gsa_pkg::CMD_ALLOC: begin
        if (req.count == '0) begin
          dec_done = 1'b1; dec_rc = gsa_pkg::RC_INVALID;
        end else if (req.count > depth) begin
          dec_done = 1'b1; dec_rc = gsa_pkg::RC_NOSPACE;
        end else if (req.count == CW'(1)) begin
          dec_pop = 1'b1;
        end else begin
          dec_scan = 1'b1;
        end
      end
      gsa_pkg::CMD_WRITE, gsa_pkg::CMD_UNMAP, gsa_pkg::CMD_READ: begin
        dec_check = 1'b1;
      end
      gsa_pkg::CMD_RELEASE: begin
        if (span > {1'b0, FULL}) begin
          dec_done = 1'b1; dec_rc = gsa_pkg::RC_RANGE;
        end else if (req.count == '0) begin
          dec_done = 1'b1;
        end else begin
          dec_check = 1'b1;
        end
      end
      gsa_pkg::CMD_MAP: begin
        if (span > {1'b0, FULL} || req.count == '0) begin
          dec_done = 1'b1; dec_rc = gsa_pkg::RC_RANGE;
        end else if (req.writable && !req.shared) begin
          dec_done = 1'b1; dec_rc = gsa_pkg::RC_INVALID;
        end else begin
          dec_check = 1'b1;
        end
      end
      default: begin
        dec_done = 1'b1; dec_rc = gsa_pkg::RC_INVALID;
      end
    endcase
  end

  // run search: a used slot or the wrap to zero restarts the run
  assign paddr   = (ctl.op == gsa_pkg::PH_SCAN) ? search_start + pcnt[SW-1:0]
                                                : req.slot + pcnt[SW-1:0];
  assign is_free = st_val[1:0] == gsa_pkg::ST_FREE;
  assign run_eff = (paddr == '0) ? '0 : run_len;
  assign run_n   = run_eff + CW'(1);
  assign first_c = (run_eff == '0) ? paddr : run_first;
  assign scan_hit  = (ctl.op == gsa_pkg::PH_SCAN) && rd_pend && is_free
                     && run_n == req.count;
  assign scan_miss = (ctl.op == gsa_pkg::PH_SCAN) && rd_pend && !scan_hit
                     && pcnt == CW'(gsa_pkg::SLOT_COUNT - 1);

  // range checks
  always_comb begin
    chk_bad = 1'b0;
    chk_rc  = gsa_pkg::RC_INVALID;
    case (req.cmd)
      gsa_pkg::CMD_WRITE: begin
        chk_bad = st_val[1:0] != gsa_pkg::ST_RESERVED;
        if (st_val[1:0] == gsa_pkg::ST_MAPPED) chk_rc = gsa_pkg::RC_BUSY;
      end
      gsa_pkg::CMD_UNMAP: chk_bad = st_val[1:0] != gsa_pkg::ST_MAPPED;
      gsa_pkg::CMD_RELEASE: begin
        chk_bad = st_val[1:0] != gsa_pkg::ST_RESERVED;
        if (st_val[1:0] == gsa_pkg::ST_MAPPED) chk_rc = gsa_pkg::RC_BUSY;
      end
      gsa_pkg::CMD_MAP: chk_bad = st_val[1:0] != gsa_pkg::ST_RESERVED;
      default: chk_bad = 1'b0;
    endcase
  end

  assign chk_last  = (ctl.op == gsa_pkg::PH_CHECK) && rd_pend && pcnt == len_chk - CW'(1);
  assign chk_fail  = (ctl.op == gsa_pkg::PH_CHECK) && rd_pend && chk_bad;
  assign chk_apply = chk_last && !chk_bad && req.cmd != gsa_pkg::CMD_READ;
  assign chk_final = chk_last && !chk_bad && req.cmd == gsa_pkg::CMD_READ;

  // compaction filter
  assign in_run = CW'(stk_val) >= CW'(sout) && CW'(stk_val) < hi_end;

  // end of counted walks
  always_comb begin
    case (ctl.op)
      gsa_pkg::PH_MARK:    walk_end = icnt == req.count - CW'(1);
      gsa_pkg::PH_APPLY:   walk_end = icnt == len_chk - CW'(1);
      gsa_pkg::PH_COMPACT: walk_end = rd_pend && pcnt == depth - CW'(1);
      default:             walk_end = 1'b0;
    endcase
  end

  assign clr = (ctl.op == gsa_pkg::PH_DECODE) || scan_hit || scan_miss
               || walk_end || chk_fail || chk_last;

  // port selection
  always_comb begin
    st_re  = 1'b0; st_ra  = '0;
    stk_re = 1'b0; stk_ra = '0;
    ent_re = 1'b0;
    st_we  = 1'b0; st_wa  = '0; st_wd = '0;
    stk_we = 1'b0; stk_wa = '0; stk_wd = '0;
    ent_we = 1'b0; ent_wa = '0;
    case (ctl.op)
      gsa_pkg::PH_POP: begin
        stk_re = 1'b1;
        stk_ra = depth[SW-1:0] - SW'(1);
      end
      gsa_pkg::PH_POP_WR: begin
        st_we  = 1'b1; st_wa = stk_val; st_wd = {1'b0, gsa_pkg::ST_RESERVED};
        ent_we = 1'b1; ent_wa = stk_val;
      end
      gsa_pkg::PH_SCAN: begin
        st_re = issue;
        st_ra = search_start + icnt[SW-1:0];
      end
      gsa_pkg::PH_MARK: begin
        st_we = 1'b1; st_wa = sout + icnt[SW-1:0]; st_wd = {1'b0, gsa_pkg::ST_RESERVED};
      end
      gsa_pkg::PH_COMPACT: begin
        stk_re = issue;
        stk_ra = icnt[SW-1:0];
        stk_we = rd_pend && !in_run;
        stk_wa = jcnt[SW-1:0];
        stk_wd = stk_val;
      end
      gsa_pkg::PH_CHECK: begin
        st_re  = issue;
        st_ra  = req.slot + icnt[SW-1:0];
        ent_re = issue;
      end
      gsa_pkg::PH_APPLY: begin
        st_wa = req.slot + icnt[SW-1:0];
        case (req.cmd)
          gsa_pkg::CMD_WRITE: begin
            ent_we = 1'b1; ent_wa = req.slot;
          end
          gsa_pkg::CMD_UNMAP: begin
            st_we = 1'b1; st_wd = {1'b0, gsa_pkg::ST_RESERVED};
          end
          gsa_pkg::CMD_RELEASE: begin
            st_we  = 1'b1; st_wd = {1'b0, gsa_pkg::ST_FREE};
            stk_we = depth < FULL;
            stk_wa = depth[SW-1:0];
            stk_wd = req.slot + icnt[SW-1:0];
          end
          gsa_pkg::CMD_MAP: begin
            st_we = 1'b1; st_wd = {!req.writable, gsa_pkg::ST_MAPPED};
          end
          default: st_we = 1'b0;
        endcase
      end
      gsa_pkg::PH_FIN_RD: begin
        st_re = 1'b1;
        st_ra = sout;
      end
      default: st_re = 1'b0;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (st_we) st_mem[st_wa] <= st_wd;
    if (st_re) st_q <= st_mem[st_ra];
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    if (stk_re) begin
      stk_q    <= stk_mem[stk_ra];
      stk_ridx <= stk_ra;
    end
    if (ent_we) begin
      dom_mem[ent_wa] <= req.domain_id;
      ref_mem[ent_wa] <= req.grant_ref;
    end
    if (ent_re) begin
      dom_q <= dom_mem[req.slot];
      ref_q <= ref_mem[req.slot];
    end
  end

  // valid bits: an unwritten entry reads as its reset value
  always_ff @(posedge clk) begin
    if (rst) begin
      st_vld  <= '0;
      stk_vld <= '0;
      st_vq   <= 1'b0;
      stk_vq  <= 1'b0;
    end else begin
      if (st_we)  st_vld[st_wa]   <= 1'b1;
      if (stk_we) stk_vld[stk_wa] <= 1'b1;
      if (st_re)  st_vq  <= st_vld[st_ra];
      if (stk_re) stk_vq <= stk_vld[stk_ra];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      search_start <= '0;
      depth        <= FULL;
      icnt         <= '0;
      pcnt         <= '0;
      jcnt         <= '0;
      rd_pend      <= 1'b0;
      run_len      <= '0;
    end else begin
      if (cfg_we) search_start <= cfg_wdata;
      if (clr) begin
        icnt    <= '0;
        pcnt    <= '0;
        jcnt    <= '0;
        rd_pend <= 1'b0;
        run_len <= '0;
      end else begin
        case (ctl.op)
          gsa_pkg::PH_SCAN, gsa_pkg::PH_CHECK, gsa_pkg::PH_COMPACT: begin
            rd_pend <= issue;
            if (issue)   icnt <= icnt + CW'(1);
            if (rd_pend) pcnt <= pcnt + CW'(1);
          end
          gsa_pkg::PH_MARK, gsa_pkg::PH_APPLY: icnt <= icnt + CW'(1);
          default: rd_pend <= 1'b0;
        endcase
        if (ctl.op == gsa_pkg::PH_SCAN && rd_pend) run_len <= is_free ? run_n : '0;
        if (stk_we && ctl.op == gsa_pkg::PH_COMPACT) jcnt <= jcnt + CW'(1);
      end
      // free depth updates
      if (ctl.op == gsa_pkg::PH_POP) depth <= depth - CW'(1);
      if (ctl.op == gsa_pkg::PH_COMPACT && walk_end)
        depth <= jcnt + CW'(!in_run);
      if (ctl.op == gsa_pkg::PH_APPLY && req.cmd == gsa_pkg::CMD_RELEASE && depth < FULL)
        depth <= depth + CW'(1);
    end
  end

  // request, result bookkeeping and output register
  always_ff @(posedge clk) begin
    if (ctl.accept) req <= in_data;
    if (ctl.op == gsa_pkg::PH_DECODE) begin
      status_r <= dec_rc;
      sout     <= req.slot;
    end
    if (ctl.op == gsa_pkg::PH_SCAN && rd_pend) run_first <= first_c;
    if (scan_hit)  sout <= first_c;
    if (scan_miss) status_r <= gsa_pkg::RC_NOSPACE;
    if (chk_fail)  status_r <= chk_rc;
    if (ctl.op == gsa_pkg::PH_POP_WR) sout <= stk_val;
    if (ctl.load_out) begin
      out_data.status        <= status_r;
      out_data.slot_out      <= sout;
      out_data.slot_state    <= st_val[1:0];
      out_data.read_only_out <= st_val[2];
      out_data.free_count    <= depth;
      if (req.cmd == gsa_pkg::CMD_READ && status_r == gsa_pkg::RC_OK) begin
        out_data.domain_out <= dom_q;
        out_data.ref_out    <= ref_q;
      end else begin
        out_data.domain_out <= '0;
        out_data.ref_out    <= '0;
      end
    end
  end

endmodule

// ===== hw/rtl/grant_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// grant_slot_allocator
// Slot table with free stack, first-fit run allocation, map and release.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one command (in_data); each transfer produces
//   exactly one result on out_valid/out_ready (out_data), in order.
//   cfg_we/cfg_wdata write search_start, the slot where the multi-slot run
//   search begins; write it only while the block is idle.
// Sequence: a decode phase, then the phase walks, then a read back of the
//   addressed slot. Release and map check the slot range, then walk it again
//   to apply. A multi-slot allocate walks the state table once (up to 128
//   reads, one per cycle on its single read port), marks count slots and
//   compacts the free stack (free depth reads). One command is in work at a
//   time.
// Reset: all slots free, free stack holds 127 down to 0, search_start 0.
//   Tables use per-entry valid bits, so no clearing pass is needed.
// Stall: the result register holds while out_ready is low; the next
//   command is still taken and waits in its last phase for the register.
// ----------------------------------------------------------------------------
module grant_slot_allocator (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  gsa_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output gsa_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [6:0]    cfg_wdata
);

  gsa_pkg::ctl_t ctl;
  gsa_pkg::sts_t sts;

  gsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  gsa_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .sts       (sts),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

endmodule

// ===== hw/rtl/gsa_checker.sv =====
// ----------------------------------------------------------------------------
// gsa_checker
// Port-level assertions for the grant slot allocator.
// ----------------------------------------------------------------------------
module gsa_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input gsa_pkg::out_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one command in work: no transfer right after a transfer
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted two commands back to back");

  // free count never exceeds the table
  a_free_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.free_count <= 8'(gsa_pkg::SLOT_COUNT))
    else $error("free count beyond table size");

  // status is a defined code
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status <= gsa_pkg::RC_RANGE)
    else $error("undefined status code");

endmodule

bind grant_slot_allocator gsa_checker u_gsa_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for grant_slot_allocator: random and directed commands
// are sent on the input channel. A scoreboard predicts each result from its
// own copy of the slot table and free stack, and checks the results in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gsa_pkg::*;

  localparam logic [2:0] CMD_UNK6 = 3'd6;
  localparam logic [2:0] CMD_UNK7 = 3'd7;

  // Slot table predictor and in-order store of expected results
  class slot_scoreboard;
    logic [1:0]  states [SLOT_COUNT];
    logic [15:0] domains [SLOT_COUNT];
    logic [31:0] refs [SLOT_COUNT];
    logic        ro [SLOT_COUNT];
    bit          written [SLOT_COUNT];
    logic [6:0]  stack [SLOT_COUNT];
    int          depth;
    int          search_start;
    out_t        expected_q[$];
    int          mismatches;

    function new();
      for (int k = 0; k < SLOT_COUNT; k++) begin
        states[k] = ST_FREE;
        domains[k] = '0;
        refs[k] = '0;
        ro[k] = 1'b0;
        written[k] = 0;
        stack[k] = 7'(SLOT_COUNT - 1 - k);
      end
      depth = SLOT_COUNT;
      search_start = 0;
      mismatches = 0;
    endfunction

    function int scan_run(int lo, int hi, int n);
      int run;
      int first;
      run = 0;
      first = 0;
      for (int i = lo; i < hi; i++) begin
        if (states[i] == ST_FREE) begin
          if (run == 0) first = i;
          run++;
          if (run == n) return first;
        end else begin
          run = 0;
        end
      end
      return -1;
    endfunction

    // note an accepted input transfer and queue its expected result
    function void note_input(in_t x);
      logic [2:0] status;
      int sout;
      int cnt;
      int s;
      int f;
      int j;
      logic [15:0] dout;
      logic [31:0] rout;
      out_t e;
      status = RC_OK;
      sout = x.slot;
      cnt = x.count;
      dout = '0;
      rout = '0;
      case (x.cmd)
        CMD_ALLOC: begin
          if (cnt == 0) status = RC_INVALID;
          else if (cnt > depth) status = RC_NOSPACE;
          else if (cnt == 1) begin
            depth--;
            s = stack[depth];
            states[s] = ST_RESERVED;
            domains[s] = x.domain_id;
            refs[s] = x.grant_ref;
            ro[s] = 1'b0;
            written[s] = 1;
            sout = s;
          end else begin
            f = scan_run(search_start, SLOT_COUNT, cnt);
            if (f < 0) f = scan_run(0, search_start, cnt);
            if (f < 0) status = RC_NOSPACE;
            else begin
              for (int i = 0; i < cnt; i++) begin
                states[f + i] = ST_RESERVED;
                ro[f + i] = 1'b0;
              end
              // compact the stack, keeping order
              j = 0;
              for (int i = 0; i < depth; i++) begin
                if (!(stack[i] >= f && stack[i] < f + cnt)) begin
                  stack[j] = stack[i];
                  j++;
                end
              end
              depth = j;
              sout = f;
            end
          end
        end
        CMD_WRITE: begin
          if (states[x.slot] == ST_FREE) status = RC_INVALID;
          else if (states[x.slot] == ST_MAPPED) status = RC_BUSY;
          else begin
            domains[x.slot] = x.domain_id;
            refs[x.slot] = x.grant_ref;
            written[x.slot] = 1;
          end
        end
        CMD_RELEASE: begin
          if (x.slot + cnt > SLOT_COUNT) status = RC_RANGE;
          else begin
            for (int i = 0; i < cnt; i++) begin
              if (status == RC_OK && states[x.slot + i] != ST_RESERVED)
                status = (states[x.slot + i] == ST_MAPPED) ? RC_BUSY : RC_INVALID;
            end
            if (status == RC_OK) begin
              for (int i = 0; i < cnt; i++) begin
                states[x.slot + i] = ST_FREE;
                ro[x.slot + i] = 1'b0;
                if (depth < SLOT_COUNT) begin
                  stack[depth] = 7'(x.slot + i);
                  depth++;
                end
              end
            end
          end
        end
        CMD_MAP: begin
          if (x.slot + cnt > SLOT_COUNT || cnt == 0) status = RC_RANGE;
          else if (x.writable && !x.shared) status = RC_INVALID;
          else begin
            for (int i = 0; i < cnt; i++)
              if (states[x.slot + i] != ST_RESERVED) status = RC_INVALID;
            if (status == RC_OK) begin
              for (int i = 0; i < cnt; i++) begin
                states[x.slot + i] = ST_MAPPED;
                ro[x.slot + i] = !x.writable;
              end
            end
          end
        end
        CMD_UNMAP: begin
          if (states[x.slot] != ST_MAPPED) status = RC_INVALID;
          else begin
            states[x.slot] = ST_RESERVED;
            ro[x.slot] = 1'b0;
          end
        end
        CMD_READ: begin
          dout = domains[x.slot];
          rout = refs[x.slot];
        end
        default: status = RC_INVALID;
      endcase
      e.status = status;
      e.slot_out = 7'(sout);
      e.slot_state = states[sout];
      e.domain_out = dout;
      e.ref_out = rout;
      e.read_only_out = ro[sout];
      e.free_count = 8'(depth);
      expected_q.push_back(e);
    endfunction

    // compare one result transfer against the oldest expectation
    function void check_result(out_t a);
      out_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", a);
        return;
      end
      e = expected_q.pop_front();
      if (a.status !== e.status || a.slot_out !== e.slot_out ||
          a.slot_state !== e.slot_state || a.domain_out !== e.domain_out ||
          a.ref_out !== e.ref_out || a.read_only_out !== e.read_only_out ||
          a.free_count !== e.free_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp st=%0d slot=%0d ss=%0d dom=%h ref=%h ro=%0d fc=%0d | act st=%0d slot=%0d ss=%0d dom=%h ref=%h ro=%0d fc=%0d",
                   e.status, e.slot_out, e.slot_state, e.domain_out, e.ref_out,
                   e.read_only_out, e.free_count, a.status, a.slot_out,
                   a.slot_state, a.domain_out, a.ref_out, a.read_only_out,
                   a.free_count);
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_t        in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_t       out_data;
  logic       cfg_we = 1'b0;
  logic [6:0] cfg_wdata = '0;
  bit         calm = 0;

  slot_scoreboard sb = new();

  grant_slot_allocator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // result side: check transfers, stall at random
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
    out_ready <= calm || ($urandom_range(0, 99) >= 35);
  end

  // one input transfer, then maybe an idle gap
  task automatic send(in_t x);
    in_data <= x;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_input(x);
    if (!calm && $urandom_range(0, 99) < 35) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_search_start(logic [6:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.search_start = v;
  endtask

  function automatic in_t item(logic [2:0] c, int s, int n, bit wr = 0, bit sh = 0);
    in_t x;
    x.cmd = c;
    x.slot = 7'(s);
    x.count = 8'(n);
    x.domain_id = 16'($urandom);
    x.grant_ref = $urandom;
    x.writable = wr;
    x.shared = sh;
    return x;
  endfunction

  function automatic int pick(logic [1:0] st);
    int hits[$];
    for (int i = 0; i < SLOT_COUNT; i++)
      if (st == ST_FREE ? sb.states[i] == ST_FREE : sb.states[i] == st) hits.push_back(i);
    if (hits.size() == 0 || $urandom_range(0, 99) < 15) return $urandom_range(0, SLOT_COUNT - 1);
    return hits[$urandom_range(0, hits.size() - 1)];
  endfunction

  function automatic int pick_written();
    int hits[$];
    for (int i = 0; i < SLOT_COUNT; i++)
      if (sb.written[i]) hits.push_back(i);
    if (hits.size() == 0) return -1;
    return hits[$urandom_range(0, hits.size() - 1)];
  endfunction

  // random command, mostly aimed at slots where it can succeed
  function automatic in_t random_item();
    int r;
    int n;
    int w;
    logic [2:0] c;
    r = $urandom_range(0, 99);
    n = $urandom_range(0, 99);
    if (r < 22) begin
      if (n < 50) return item(CMD_ALLOC, $urandom, 1);
      if (n < 85) return item(CMD_ALLOC, $urandom, $urandom_range(2, 6));
      if (n < 95) return item(CMD_ALLOC, $urandom, $urandom_range(7, 40));
      return item(CMD_ALLOC, $urandom, $urandom_range(0, 128));
    end
    if (r < 35) return item(CMD_WRITE, pick(ST_RESERVED), $urandom);
    if (r < 55) return item(CMD_RELEASE, pick(ST_RESERVED),
                           n < 80 ? 1 : (n < 95 ? $urandom_range(0, 4) : $urandom_range(0, 128)));
    if (r < 70) return item(CMD_MAP, pick(ST_RESERVED),
                           n < 90 ? $urandom_range(1, 2) : $urandom_range(0, 128),
                           $urandom_range(0, 1), n < 80 ? 1 : $urandom_range(0, 1));
    if (r < 82) return item(CMD_UNMAP, pick(ST_MAPPED), $urandom);
    if (r < 95) begin
      w = pick_written();
      if (w >= 0) return item(CMD_READ, w, $urandom);
      return item(CMD_ALLOC, 0, 1);
    end
    // noise: unknown codes and random fields on the other commands
    c = 3'($urandom_range(0, 7));
    if (c == CMD_READ) c = CMD_UNK6;
    return item(c, $urandom, $urandom_range(0, 255) % 129, $urandom_range(0, 1),
                $urandom_range(0, 1));
  endfunction

  initial begin
    logic [6:0] starts [5];
    in_t x;
    starts[0] = 7'd127;
    starts[1] = 7'($urandom);
    starts[2] = 7'd0;
    starts[3] = 7'd64;
    starts[4] = 7'($urandom);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    set_search_start(7'd0);

    // directed: extremes, each command and its error paths
    x = item(CMD_ALLOC, 0, 1);
    x.domain_id = 16'hFFFF;
    x.grant_ref = 32'hFFFF_FFFF;
    send(x);
    send(item(CMD_ALLOC, 0, 0));
    send(item(CMD_READ, 0, 0));
    x = item(CMD_WRITE, 0, 0);
    x.domain_id = '0;
    x.grant_ref = '0;
    send(x);
    send(item(CMD_READ, 0, 0));
    send(item(CMD_WRITE, 5, 0));
    send(item(CMD_ALLOC, 0, 128));
    send(item(CMD_ALLOC, 0, 3));
    send(item(CMD_MAP, 1, 3, 1, 0));
    send(item(CMD_MAP, 1, 3, 1, 1));
    send(item(CMD_WRITE, 1, 0));
    send(item(CMD_RELEASE, 1, 3));
    send(item(CMD_UNMAP, 2, 0));
    send(item(CMD_UNMAP, 2, 0));
    send(item(CMD_RELEASE, 0, 0));
    send(item(CMD_RELEASE, 127, 2));
    send(item(CMD_MAP, 0, 0));
    send(item(CMD_MAP, 120, 8));
    send(item(CMD_RELEASE, 5, 1));
    send(item(CMD_UNMAP, 1, 0));
    send(item(CMD_UNMAP, 3, 0));
    send(item(CMD_RELEASE, 0, 4));
    send(item(CMD_UNK6, 0, 0));
    send(item(CMD_UNK7, 127, 255, 1, 1));
    send(item(CMD_ALLOC, 0, 128));
    send(item(CMD_RELEASE, 0, 128));

    // random phases over several search starts, one phase with no idling
    for (int p = 0; p < 5; p++) begin
      set_search_start(starts[p]);
      calm = (p == 2);
      repeat (100) send(random_item());
    end
    calm = 0;
    drain();
    repeat (300) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule

// ===== files.f =====
hw/rtl/gsa_pkg.sv
hw/rtl/gsa_ctrl.sv
hw/rtl/gsa_datapath.sv
hw/rtl/grant_slot_allocator.sv
hw/rtl/gsa_checker.sv
test/tb.sv
